### sv/sdrp_pkg.sv
// Shared types and constants for the SCAN disk request picker.
// Holds field widths, operation and status codes and the cell control struct.
// No dependencies.
package sdrp_pkg;

  localparam int TableDepth   = 16;
  localparam int CylinderBits = 16;

  localparam int OpW       = 2;
  localparam int StatusW   = 2;
  localparam int TagW      = 8;
  localparam int CylPortW  = 16;
  localparam int SlotPortW = 4;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_SELECT = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd2;

  localparam logic [StatusW-1:0] STAT_DONE    = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL    = 2'd1;
  localparam logic [StatusW-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [StatusW-1:0] STAT_NO_SLOT = 2'd3;

  // Candidate lanes carried along the cell chain during a select scan
  localparam int NumKinds  = 3;
  localparam int KindMatch = 0;  // first entry on the head cylinder
  localparam int KindUp    = 1;  // nearest entry above the head
  localparam int KindDown  = 2;  // nearest entry below the head

  typedef struct packed {
    logic load;   // take the incoming request
    logic shift;  // take the neighbor's entry (remove closes the gap)
    logic drop;   // entry leaves the table
  } cell_ctl_t;

endpackage

### sv/sdrp_cell.sv
// One table slot of the request picker: stored request plus a scan stage.
// Depends on sdrp_pkg.
module sdrp_cell
  import sdrp_pkg::*;
#(
  parameter int Depth   = TableDepth,
  parameter int CylBits = CylinderBits,
  parameter int Index   = 0,
  localparam int IdxW   = $clog2(Depth),
  localparam int CandW  = 1 + IdxW + CylBits + TagW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cell_ctl_t                          ctl_i,
  input  logic [CylBits-1:0]                 new_cyl_i,
  input  logic [TagW-1:0]                    new_tag_i,
  input  logic [CylBits-1:0]                 nbr_cyl_i,
  input  logic [TagW-1:0]                    nbr_tag_i,
  input  logic [CylBits-1:0]                 head_i,
  input  logic                               tok_vld_i,
  input  logic [NumKinds-1:0][CandW-1:0]     cand_i,
  output logic                               tok_vld_o,
  output logic [NumKinds-1:0][CandW-1:0]     cand_o,
  output logic                               valid_o,
  output logic [CylBits-1:0]                 cyl_o,
  output logic [TagW-1:0]                    tag_o
);

  typedef struct packed {
    logic               hit;
    logic [IdxW-1:0]    slot;
    logic [CylBits-1:0] cyl;
    logic [TagW-1:0]    tag;
  } cand_t;

  localparam logic [IdxW-1:0] MySlot = IdxW'(Index);

  logic               valid_q;
  logic [CylBits-1:0] cyl_q;
  logic [TagW-1:0]    tag_q;
  logic               tok_vld_q;
  logic [NumKinds-1:0][CandW-1:0] cand_q;

  cand_t cin  [NumKinds];
  cand_t cnx  [NumKinds];
  cand_t mine;

  always_comb begin
    mine.hit  = 1'b1;
    mine.slot = MySlot;
    mine.cyl  = cyl_q;
    mine.tag  = tag_q;
    for (int k = 0; k < NumKinds; k++) begin
      cin[k] = cand_t'(cand_i[k]);
      cnx[k] = cin[k];
    end
    // strict compares keep the earliest slot on ties
    if (valid_q) begin
      if (!cin[KindMatch].hit && cyl_q == head_i) begin
        cnx[KindMatch] = mine;
      end
      if (cyl_q > head_i && (!cin[KindUp].hit || cyl_q < cin[KindUp].cyl)) begin
        cnx[KindUp] = mine;
      end
      if (cyl_q < head_i && (!cin[KindDown].hit || cyl_q > cin[KindDown].cyl)) begin
        cnx[KindDown] = mine;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      if (ctl_i.load) begin
        valid_q <= 1'b1;
      end else if (ctl_i.drop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumKinds; k++) begin
      cand_q[k] <= CandW'(cnx[k]);
    end
    if (ctl_i.load) begin
      cyl_q <= new_cyl_i;
      tag_q <= new_tag_i;
    end else if (ctl_i.shift) begin
      cyl_q <= nbr_cyl_i;
      tag_q <= nbr_tag_i;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign cand_o    = cand_q;
  assign valid_o   = valid_q;
  assign cyl_o     = cyl_q;
  assign tag_o     = tag_q;

endmodule

### sv/scan_disk_request_picker_core.sv
// Insert, remove: the result goes to the pending-result register, then the output
//   register; the next item is taken once the result is in the output register.
// Select: a scan token walks the cell chain one cell per cycle; the pick at its end
//   is handed off the same way. Select on an empty table skips the scan, like insert.
// Reset (async, active low) empties the table, points the sweep toward larger cylinders
//   and clears the handshake; stored cylinders and tags are not cleared.
// Depends on sdrp_pkg and sdrp_cell.
module scan_disk_request_picker_core
  import sdrp_pkg::*;
#(
  parameter int Depth   = TableDepth,
  parameter int CylBits = CylinderBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OpW-1:0]       operation_i,
  input  logic [CylPortW-1:0]  req_cylinder_i,
  input  logic [TagW-1:0]      req_tag_i,
  input  logic [CylPortW-1:0]  head_cylinder_i,
  input  logic [SlotPortW-1:0] slot_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [StatusW-1:0]   status_o,
  output logic [SlotPortW-1:0] chosen_slot_o,
  output logic [CylPortW-1:0]  chosen_cylinder_o,
  output logic [TagW-1:0]      chosen_tag_o,
  output logic                 moving_inward_o
);

  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int CmpW  = (CntW > SlotPortW) ? CntW : SlotPortW;
  localparam int CandW = 1 + IdxW + CylBits + TagW;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_SCAN = 2'd1;  // select token travels the chain
  localparam logic [1:0] ST_PUT  = 2'd2;  // result waits for the output register

  typedef struct packed {
    logic               hit;
    logic [IdxW-1:0]    slot;
    logic [CylBits-1:0] cyl;
    logic [TagW-1:0]    tag;
  } cand_t;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                sweep_q, sweep_d;
  logic [CylBits-1:0]  head_q, head_d;
  logic                start_q;
  logic                start_d;

  // pending result
  logic [StatusW-1:0]   rs_status_q, rs_status_d;
  logic [SlotPortW-1:0] rs_slot_q, rs_slot_d;
  logic [CylPortW-1:0]  rs_cyl_q, rs_cyl_d;
  logic [TagW-1:0]      rs_tag_q, rs_tag_d;
  logic                 rs_dir_q, rs_dir_d;

  // output register
  logic                 out_vld_q;
  logic                 out_load;
  logic [StatusW-1:0]   out_status_q;
  logic [SlotPortW-1:0] out_slot_q;
  logic [CylPortW-1:0]  out_cyl_q;
  logic [TagW-1:0]      out_tag_q;
  logic                 out_dir_q;

  logic                 acc;
  logic                 full;
  logic                 slot_ok;
  logic [IdxW-1:0]      rm_idx;
  logic [CylBits-1:0]   new_cyl;

  // cell chain wiring
  cell_ctl_t                      ctl        [Depth];
  logic [CylBits-1:0]             cell_cyl   [Depth];
  logic [TagW-1:0]                cell_tag   [Depth];
  logic [Depth-1:0]               cell_valid;
  logic [Depth-1:0]               exp_valid;
  logic                           tok_w      [Depth+1];
  logic [NumKinds-1:0][CandW-1:0] cand_w     [Depth+1];

  cand_t fin [NumKinds];
  cand_t pick;
  logic  flip;

  assign acc     = in_valid_i && !in_stall_o;
  assign full    = (count_q == CntW'(Depth));
  assign slot_ok = (CmpW'(slot_index_i) < CmpW'(count_q));
  assign rm_idx  = IdxW'(slot_index_i);
  assign new_cyl = CylBits'(req_cylinder_i);

  assign tok_w[0]  = start_q;
  assign cand_w[0] = '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    localparam logic [CntW-1:0] Pos     = CntW'(g);
    localparam logic [CntW-1:0] PosNext = CntW'(g + 1);

    logic [CylBits-1:0] nbr_cyl;
    logic [TagW-1:0]    nbr_tag;

    if (g < Depth - 1) begin : g_nbr
      assign nbr_cyl = cell_cyl[g+1];
      assign nbr_tag = cell_tag[g+1];
    end else begin : g_end
      assign nbr_cyl = '0;
      assign nbr_tag = '0;
    end

    // insert appends at the fill count; remove slides later entries down one
    assign ctl[g].load  = acc && operation_i == OP_INSERT && !full && Pos == count_q;
    assign ctl[g].shift = acc && operation_i == OP_REMOVE && slot_ok &&
                          CmpW'(Pos) >= CmpW'(slot_index_i) && PosNext < count_q;
    assign ctl[g].drop  = acc && operation_i == OP_REMOVE && slot_ok && PosNext == count_q;

    assign exp_valid[g] = (Pos < count_q);

    sdrp_cell #(
      .Depth   (Depth),
      .CylBits (CylBits),
      .Index   (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[g]),
      .new_cyl_i (new_cyl),
      .new_tag_i (req_tag_i),
      .nbr_cyl_i (nbr_cyl),
      .nbr_tag_i (nbr_tag),
      .head_i    (head_q),
      .tok_vld_i (tok_w[g]),
      .cand_i    (cand_w[g]),
      .tok_vld_o (tok_w[g+1]),
      .cand_o    (cand_w[g+1]),
      .valid_o   (cell_valid[g]),
      .cyl_o     (cell_cyl[g]),
      .tag_o     (cell_tag[g])
    );
  end

  // SCAN rule at the chain's end: head hit first, else nearest ahead, else flip
  always_comb begin
    for (int k = 0; k < NumKinds; k++) begin
      fin[k] = cand_t'(cand_w[Depth][k]);
    end
    flip = 1'b0;
    if (fin[KindMatch].hit) begin
      pick = fin[KindMatch];
    end else if (sweep_q) begin
      if (fin[KindUp].hit) begin
        pick = fin[KindUp];
      end else begin
        flip = 1'b1;
        pick = fin[KindDown];
      end
    end else begin
      if (fin[KindDown].hit) begin
        pick = fin[KindDown];
      end else begin
        flip = 1'b1;
        pick = fin[KindUp];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sweep_d     = sweep_q;
    head_d      = head_q;
    start_d     = 1'b0;
    rs_status_d = rs_status_q;
    rs_slot_d   = rs_slot_q;
    rs_cyl_d    = rs_cyl_q;
    rs_tag_d    = rs_tag_q;
    rs_dir_d    = rs_dir_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d     = ST_PUT;
          rs_status_d = STAT_DONE;
          rs_slot_d   = '0;
          rs_cyl_d    = '0;
          rs_tag_d    = '0;
          rs_dir_d    = sweep_q;
          case (operation_i)
            OP_INSERT: begin
              if (full) begin
                rs_status_d = STAT_FULL;
              end else begin
                rs_slot_d = SlotPortW'(count_q);
                rs_cyl_d  = CylPortW'(new_cyl);
                rs_tag_d  = req_tag_i;
                count_d   = count_q + CntW'(1);
              end
            end
            OP_SELECT: begin
              if (count_q == '0) begin
                rs_status_d = STAT_EMPTY;
              end else begin
                head_d  = CylBits'(head_cylinder_i);
                start_d = 1'b1;
                state_d = ST_SCAN;
              end
            end
            OP_REMOVE: begin
              if (!slot_ok) begin
                rs_status_d = STAT_NO_SLOT;
              end else begin
                rs_slot_d = slot_index_i;
                rs_cyl_d  = CylPortW'(cell_cyl[rm_idx]);
                rs_tag_d  = cell_tag[rm_idx];
                count_d   = count_q - CntW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (tok_w[Depth]) begin
          state_d = ST_PUT;
          if (flip) begin
            sweep_d = !sweep_q;
          end
          rs_dir_d = flip ? !sweep_q : sweep_q;
          if (pick.hit) begin
            rs_status_d = STAT_DONE;
            rs_slot_d   = SlotPortW'(pick.slot);
            rs_cyl_d    = CylPortW'(pick.cyl);
            rs_tag_d    = pick.tag;
          end else begin
            rs_status_d = STAT_EMPTY;
            rs_slot_d   = '0;
            rs_cyl_d    = '0;
            rs_tag_d    = '0;
          end
        end
      end
      ST_PUT: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // the result moves on when the output register is empty or being drained
  assign out_load = (state_q == ST_PUT) && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      sweep_q   <= 1'b1;
      start_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sweep_q   <= sweep_d;
      start_q   <= start_d;
      out_vld_q <= out_load || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    head_q      <= head_d;
    rs_status_q <= rs_status_d;
    rs_slot_q   <= rs_slot_d;
    rs_cyl_q    <= rs_cyl_d;
    rs_tag_q    <= rs_tag_d;
    rs_dir_q    <= rs_dir_d;
    if (out_load) begin
      out_status_q <= rs_status_q;
      out_slot_q   <= rs_slot_q;
      out_cyl_q    <= rs_cyl_q;
      out_tag_q    <= rs_tag_q;
      out_dir_q    <= rs_dir_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_vld_q;
  assign status_o          = out_status_q;
  assign chosen_slot_o     = out_slot_q;
  assign chosen_cylinder_o = out_cyl_q;
  assign chosen_tag_o      = out_tag_q;
  assign moving_inward_o   = out_dir_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count beyond table depth");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid == exp_valid)
    else $error("cell valid bits disagree with fill count");

  a_out_from_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_PUT)
    else $error("output loaded outside result hand-off");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_w[Depth] |-> state_q == ST_SCAN)
    else $error("scan token left the chain while not scanning");

  a_sweep_at_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sweep_q) |-> $past(state_q == ST_SCAN && tok_w[Depth]))
    else $error("sweep direction changed outside a select decision");

endmodule

### tb/tb_top.sv
// Self-checking testbench for scan_disk_request_picker_core: a directed table, then random traffic.
// A behavioral SCAN scheduler tracks every accepted item and predicts each result item.
// Depends on sdrp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import sdrp_pkg::*;

  // Fourth opcode is not decoded by the block: it must answer "done" with zeros.
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  localparam int RAND_ITEMS  = 1900;
  localparam int LONG_HOLD   = 250;             // receiver hold-off, in cycles
  localparam int SETTLE_CYC  = TableDepth + 8;  // longer than one select scan
  localparam int PRINT_LIMIT = 60;
  localparam int TIMEOUT_NS  = 10_000_000;

  typedef struct packed {
    logic [OpW-1:0]       op;
    logic [CylPortW-1:0]  req_cyl;
    logic [TagW-1:0]      req_tag;
    logic [CylPortW-1:0]  head;
    logic [SlotPortW-1:0] slot;
  } disk_req_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [SlotPortW-1:0] slot;
    logic [CylPortW-1:0]  cyl;
    logic [TagW-1:0]      tag;
    logic                 inward;
  } disk_res_t;

  // One directed row: typed=1 means the expected item is written out in the row
  typedef struct packed {
    disk_req_t req;
    logic      typed;
    disk_res_t want;
  } plan_row_t;

  logic                 clk             = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [OpW-1:0]       operation       = '0;
  logic [CylPortW-1:0]  req_cylinder    = '0;
  logic [TagW-1:0]      req_tag         = '0;
  logic [CylPortW-1:0]  head_cylinder   = '0;
  logic [SlotPortW-1:0] slot_index      = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [StatusW-1:0]   status;
  logic [SlotPortW-1:0] chosen_slot;
  logic [CylPortW-1:0]  chosen_cylinder;
  logic [TagW-1:0]      chosen_tag;
  logic                 moving_inward;

  scan_disk_request_picker_core DUT (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .req_cylinder_i    (req_cylinder),
    .req_tag_i         (req_tag),
    .head_cylinder_i   (head_cylinder),
    .slot_index_i      (slot_index),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .chosen_slot_o     (chosen_slot),
    .chosen_cylinder_o (chosen_cylinder),
    .chosen_tag_o      (chosen_tag),
    .moving_inward_o   (moving_inward)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler model: pending table in arrival order plus the sweep direction.
  // ---------------------------------------------------------------------------
  logic [CylPortW-1:0] sched_cyl [TableDepth];
  logic [TagW-1:0]     sched_tag [TableDepth];
  int                  sched_count = 0;
  logic                sweep_up    = 1'b1;

  disk_res_t pending_results [$];
  int        mismatches = 0;
  int        burst_left = 0;
  logic      long_hold_pending = 1'b0;

  // Nearest request strictly on the given side of the head; earliest slot wins a tie.
  function automatic int closest_in_sweep(input logic [CylPortW-1:0] head, input logic up);
    int          best;
    int unsigned best_dist;
    int unsigned delta;
    best      = -1;
    best_dist = 0;
    for (int i = 0; i < sched_count; i++) begin
      if (up ? (sched_cyl[i] > head) : (sched_cyl[i] < head)) begin
        delta = up ? (sched_cyl[i] - head) : (head - sched_cyl[i]);
        if (best < 0 || delta < best_dist) begin
          best      = i;
          best_dist = delta;
        end
      end
    end
    return best;
  endfunction

  // Applies one item to the model and returns the result item it should produce.
  function automatic disk_res_t apply_request(input disk_req_t r);
    disk_res_t res;
    int        pick;
    res  = '0;
    pick = -1;
    case (r.op)
      OP_INSERT: begin
        if (sched_count >= TableDepth) begin
          res.status = STAT_FULL;
        end else begin
          sched_cyl[sched_count] = r.req_cyl;
          sched_tag[sched_count] = r.req_tag;
          res.status = STAT_DONE;
          res.slot   = SlotPortW'(sched_count);
          res.cyl    = r.req_cyl;
          res.tag    = r.req_tag;
          sched_count++;
        end
      end
      OP_SELECT: begin
        if (sched_count == 0) begin
          res.status = STAT_EMPTY;  // direction left alone
        end else begin
          // a request on the head cylinder wins outright, oldest first
          for (int i = 0; i < sched_count; i++) begin
            if (pick < 0 && sched_cyl[i] == r.head) pick = i;
          end
          if (pick < 0) begin
            pick = closest_in_sweep(r.head, sweep_up);
            if (pick < 0) begin
              // nothing ahead: reverse the sweep for good and look the other way
              sweep_up = ~sweep_up;
              pick     = closest_in_sweep(r.head, sweep_up);
            end
          end
          if (pick < 0) begin
            res.status = STAT_EMPTY;
          end else begin
            res.status = STAT_DONE;
            res.slot   = SlotPortW'(pick);
            res.cyl    = sched_cyl[pick];
            res.tag    = sched_tag[pick];
          end
        end
      end
      OP_REMOVE: begin
        if (int'(r.slot) >= sched_count) begin
          res.status = STAT_NO_SLOT;
        end else begin
          res.status = STAT_DONE;
          res.slot   = r.slot;
          res.cyl    = sched_cyl[r.slot];
          res.tag    = sched_tag[r.slot];
          // close the gap so slot order stays arrival order
          for (int i = int'(r.slot); i < sched_count - 1; i++) begin
            sched_cyl[i] = sched_cyl[i + 1];
            sched_tag[i] = sched_tag[i + 1];
          end
          sched_count--;
        end
      end
      default: ;  // unused opcode: no state change, zero result
    endcase
    res.inward = sweep_up;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random item generation, steered by the model so selects hit real entries.
  // ---------------------------------------------------------------------------
  function automatic logic [CylPortW-1:0] random_cyl();
    logic [CylPortW-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 16'h3FF8 + 16'($urandom_range(0, 16));  // tight cluster: duplicates, ties
      3:       c = '0;
      4:       c = '1;
      default: c = 16'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [CylPortW-1:0] random_head();
    logic [CylPortW-1:0] h;
    int                  k;
    k = (sched_count > 0) ? $urandom_range(0, sched_count - 1) : 0;
    h = random_cyl();
    if (sched_count > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: h = sched_cyl[k];          // exact hit
        3:       h = sched_cyl[k] + 16'd1;  // just past an entry
        4:       h = sched_cyl[k] - 16'd1;  // just short of one
        default: ;
      endcase
    end
    return h;
  endfunction

  // bias 0 fills the table, 1 drains it, 2 is an even mix
  function automatic disk_req_t random_request(input int bias);
    disk_req_t r;
    int        roll;
    int        ins_pct;
    int        sel_pct;
    roll = $urandom_range(0, 99);
    case (bias)
      0:       begin ins_pct = 60; sel_pct = 28; end
      1:       begin ins_pct = 15; sel_pct = 33; end
      default: begin ins_pct = 35; sel_pct = 38; end
    endcase
    if (roll < ins_pct)                r.op = OP_INSERT;
    else if (roll < ins_pct + sel_pct) r.op = OP_SELECT;
    else if (roll < 98)                r.op = OP_REMOVE;
    else                               r.op = OP_UNUSED;
    r.req_cyl = random_cyl();
    r.req_tag = 8'($urandom);
    r.head    = random_head();
    if (sched_count > 0 && $urandom_range(0, 9) < 8)
      r.slot = SlotPortW'($urandom_range(0, sched_count - 1));
    else
      r.slot = SlotPortW'($urandom_range(0, 15));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Bursts of random length; between bursts valid may be lowered for a random gap.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // Holds the item until accepted, then records what it should produce.
  task automatic offer(input disk_req_t r, input logic typed, input disk_res_t want);
    disk_res_t predicted;
    in_valid      <= 1'b1;
    operation     <= r.op;
    req_cylinder  <= r.req_cyl;
    req_tag       <= r.req_tag;
    head_cylinder <= r.head;
    slot_index    <= r.slot;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Sender goes quiet until every result item has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern of its own, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int span;
    int beat;
    beat = 0;
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        // mode: never stall, light, half, or heavy stalling
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
        repeat (span) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= (beat % 4 != 0);
          endcase
          beat++;
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH %s: got %0h, wanted %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    disk_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result item with none pending", 32'(status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          note_mismatch("status", 32'(status), 32'(want.status));
        if (chosen_slot !== want.slot)
          note_mismatch("chosen_slot", 32'(chosen_slot), 32'(want.slot));
        if (chosen_cylinder !== want.cyl)
          note_mismatch("chosen_cylinder", 32'(chosen_cylinder), 32'(want.cyl));
        if (chosen_tag !== want.tag)
          note_mismatch("chosen_tag", 32'(chosen_tag), 32'(want.tag));
        if (moving_inward !== want.inward)
          note_mismatch("moving_inward", 32'(moving_inward), 32'(want.inward));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan [$];
    int        phase_left;
    int        bias;

    // Directed walk: empty-table errors, opcode that does nothing, extremes,
    // exact hit, nearest ahead, sweep reversal, ties, removes at both ends.
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b1,
                     '{STAT_EMPTY, 4'd0, 16'h0000, 8'h00, 1'b1}});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b1,
                     '{STAT_NO_SLOT, 4'd0, 16'h0000, 8'h00, 1'b1}});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd15}, 1'b1,
                     '{STAT_NO_SLOT, 4'd0, 16'h0000, 8'h00, 1'b1}});
    plan.push_back('{'{OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 4'd15}, 1'b1,
                     '{STAT_DONE, 4'd0, 16'h0000, 8'h00, 1'b1}});
    plan.push_back('{'{OP_INSERT, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b1,
                     '{STAT_DONE, 4'd0, 16'h0000, 8'h00, 1'b1}});
    plan.push_back('{'{OP_INSERT, 16'hFFFF, 8'hFF, 16'h0000, 4'd0},  1'b1,
                     '{STAT_DONE, 4'd1, 16'hFFFF, 8'hFF, 1'b1}});
    plan.push_back('{'{OP_INSERT, 16'h0100, 8'h5A, 16'h0000, 4'd0},  1'b1,
                     '{STAT_DONE, 4'd2, 16'h0100, 8'h5A, 1'b1}});
    plan.push_back('{'{OP_INSERT, 16'h0300, 8'hA5, 16'h0000, 4'd0},  1'b1,
                     '{STAT_DONE, 4'd3, 16'h0300, 8'hA5, 1'b1}});
    plan.push_back('{'{OP_INSERT, 16'h0100, 8'h3C, 16'h0000, 4'd0},  1'b1,
                     '{STAT_DONE, 4'd4, 16'h0100, 8'h3C, 1'b1}});
    // exact hit on a duplicated cylinder, nearest above, hit at the top extreme
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h0100, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h0200, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'hFFFF, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd1},  1'b1,
                     '{STAT_DONE, 4'd1, 16'hFFFF, 8'hFF, 1'b1}});
    // nothing above the head: sweep turns outward; then a tie below
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h0400, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h0200, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b0, '0});
    // head at zero with nothing below: sweep turns back inward
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd15}, 1'b1,
                     '{STAT_NO_SLOT, 4'd0, 16'h0000, 8'h00, 1'b1}});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd3},  1'b1,
                     '{STAT_NO_SLOT, 4'd0, 16'h0000, 8'h00, 1'b1}});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd2},  1'b0, '0});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd0},  1'b0, '0});
    plan.push_back('{'{OP_SELECT, 16'h0000, 8'h00, 16'h8000, 4'd0},  1'b1,
                     '{STAT_EMPTY, 4'd0, 16'h0000, 8'h00, 1'b1}});

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      pace();
      offer(plan[i].req, plan[i].typed, plan[i].want);
    end
    drain_results();

    // Random phases alternate between filling, draining and mixed traffic so
    // the table sweeps through empty, partly full and full.
    phase_left = 0;
    bias       = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        bias       = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      if (n == RAND_ITEMS / 3) begin
        // receiver holds off while the sender keeps pushing: the block must back up
        long_hold_pending = 1'b1;
        burst_left        = 120;
      end
      if (n == (2 * RAND_ITEMS) / 3) drain_results();
      pace();
      offer(random_request(bias), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("scan_disk_request_picker_core test passed");
    else
      $display("scan_disk_request_picker_core test failed");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("scan_disk_request_picker_core test failed");
    $finish;
  end

endmodule

### files.f
sv/sdrp_pkg.sv
sv/sdrp_cell.sv
sv/scan_disk_request_picker_core.sv
tb/tb_top.sv
